@@ src/bfa_pkg.sv @@
// Shared types and constants for the best-fit block allocator.
package bfa_pkg;

  localparam int unsigned AddrW = 32;
  localparam int unsigned HdrW  = 12;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] CfgPoolSize   = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgHeaderSize = 1'b1;

  localparam logic [AddrW-1:0] PoolSizeReset   = 32'd2097152;
  localparam logic [HdrW-1:0]  HeaderSizeReset = 12'd64;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  // one table entry as held in memory: flags, start and data size
  typedef struct packed {
    logic             valid;
    logic             used;
    logic [AddrW-1:0] start;
    logic [AddrW-1:0] size;
  } entry_t;

endpackage

@@ src/best_fit_block_allocator.sv @@
// One item at a time; each request sweeps the entry RAM one entry per cycle
// (one scan for alloc, a find and a neighbor scan for free).
// Result sits in an output register; the next beat is taken once it is gone.
// Reset (async, active low) and any config write start a clearing pass that
// writes every entry and rebuilds the table; input is held off until it is done.
module best_fit_block_allocator #(
  parameter int unsigned MAX_BLOCKS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // request_size[31:0], data_offset[63:32]
  input  logic        s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // result_offset[31:0], ok[32], zero fill
);

  localparam int unsigned IdxW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CntW = IdxW + 1;
  localparam int unsigned EntW = $bits(bfa_pkg::entry_t);
  localparam logic [CntW-1:0] LastCnt = CntW'(MAX_BLOCKS);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_BLOCKS - 1);

  typedef enum logic [3:0] {
    StClear, StIdle, StScanA, StWrA0, StWrA1,
    StScanF, StScanN, StWrN, StWrP, StWrC, StDone
  } state_e;

  state_e state_q;
  logic [31:0] pool_q;
  logic [11:0] hdr_q;
  logic [31:0] req_q, off_q;
  logic [CntW-1:0] cnt_q;       // issued read index, or clear index
  logic [IdxW-1:0] ridx_q;      // index of the data now on rdata
  logic rvld_q;
  logic best_v_q, slot_v_q, cur_v_q, nxt_v_q, prv_v_q;
  logic [IdxW-1:0] best_q, slot_q, cur_q, nxt_q, prv_q;
  bfa_pkg::entry_t best_e_q, cur_e_q, nxt_e_q, prv_e_q;
  logic [31:0] res_q;
  logic ok_q;

  logic we;
  logic [IdxW-1:0] waddr, raddr;
  bfa_pkg::entry_t wdata, rdata;

  bfa_ram #(.Width(EntW), .Depth(MAX_BLOCKS)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign raddr = cnt_q[IdxW-1:0];

  logic [32:0] need, rd_end, cur_end;
  assign need    = {1'b0, req_q} + 33'(hdr_q);
  assign rd_end  = {1'b0, rdata.start} + 33'(hdr_q) + {1'b0, rdata.size};
  assign cur_end = {1'b0, cur_e_q.start} + 33'(hdr_q) + {1'b0, cur_e_q.size};

  logic [31:0] d_off, first_size, nxt_sz, prv_sz;
  assign d_off      = best_e_q.start + 32'(hdr_q);
  assign first_size = (pool_q > 32'(hdr_q)) ? pool_q - 32'(hdr_q) : '0;
  assign nxt_sz     = cur_e_q.size + 32'(hdr_q) + nxt_e_q.size;
  assign prv_sz     = prv_e_q.size + 32'(hdr_q) + cur_e_q.size;

  logic cur_hit;
  assign cur_hit = rdata.valid && rdata.used &&
                   ({1'b0, rdata.start} + 33'(hdr_q) == {1'b0, off_q});

  // write port mux
  always_comb begin
    we = 1'b0;
    waddr = '0;
    wdata = '0;
    unique case (state_q)
      StClear: begin
        we = 1'b1; waddr = cnt_q[IdxW-1:0];
        if (cnt_q == '0) begin
          wdata.valid = 1'b1; wdata.size = first_size;
        end
      end
      StWrA0: begin
        we = best_v_q && slot_v_q; waddr = slot_q;
        wdata.valid = 1'b1;
        wdata.start = d_off + req_q;
        wdata.size  = best_e_q.size - need[31:0];
      end
      StWrA1: begin
        we = 1'b1; waddr = best_q;
        wdata = best_e_q; wdata.used = 1'b1; wdata.size = req_q;
      end
      StWrN: begin
        // absorbed neighbor goes invalid
        we = nxt_v_q; waddr = nxt_q;
      end
      StWrP: begin
        we = prv_v_q; waddr = prv_q;
        wdata = prv_e_q; wdata.size = prv_sz;
      end
      StWrC: begin
        we = 1'b1; waddr = cur_q;
        if (!prv_v_q) begin
          wdata = cur_e_q; wdata.used = 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign s_axis_tready = (state_q == StIdle) && !m_axis_tvalid && !cfg_we_i;
  assign m_axis_tdata  = {7'd0, ok_q, res_q};

  logic scan_st, scan_end;
  assign scan_st  = (state_q == StScanA) || (state_q == StScanF) || (state_q == StScanN);
  assign scan_end = rvld_q && (ridx_q == LastIdx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      pool_q <= bfa_pkg::PoolSizeReset;
      hdr_q <= bfa_pkg::HeaderSizeReset;
      m_axis_tvalid <= 1'b0;
      cnt_q <= '0;
      rvld_q <= 1'b0;
      ridx_q <= '0;
      res_q <= '0;
      ok_q <= 1'b0;
      req_q <= '0;
      off_q <= '0;
      best_v_q <= 1'b0; slot_v_q <= 1'b0; cur_v_q <= 1'b0;
      nxt_v_q <= 1'b0; prv_v_q <= 1'b0;
      best_q <= '0; slot_q <= '0; cur_q <= '0; nxt_q <= '0; prv_q <= '0;
      best_e_q <= '0; cur_e_q <= '0; nxt_e_q <= '0; prv_e_q <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      rvld_q <= scan_st && (cnt_q != LastCnt);
      ridx_q <= cnt_q[IdxW-1:0];
      if (cfg_we_i) begin
        if (cfg_idx_i == bfa_pkg::CfgPoolSize) pool_q <= cfg_data_i;
        else hdr_q <= cfg_data_i[11:0];
        cnt_q <= '0;
        state_q <= StClear;
      end else begin
        unique case (state_q)
          StClear: begin
            if (cnt_q == {1'b0, LastIdx}) state_q <= StIdle;
            else cnt_q <= cnt_q + 1'b1;
          end
          StIdle: begin
            if (s_axis_tvalid && s_axis_tready) begin
              req_q <= s_axis_tdata[31:0];
              off_q <= s_axis_tdata[63:32];
              best_v_q <= 1'b0; slot_v_q <= 1'b0; cur_v_q <= 1'b0;
              nxt_v_q <= 1'b0; prv_v_q <= 1'b0;
              cnt_q <= '0;
              state_q <= (s_axis_tuser == bfa_pkg::OpAlloc) ? StScanA : StScanF;
            end
          end
          StScanA: begin
            if (cnt_q != LastCnt) cnt_q <= cnt_q + 1'b1;
            if (rvld_q) begin
              if (!rdata.valid) begin
                if (!slot_v_q) begin slot_v_q <= 1'b1; slot_q <= ridx_q; end
              end else if (!rdata.used && {1'b0, rdata.size} > need &&
                           (!best_v_q || rdata.size < best_e_q.size)) begin
                best_v_q <= 1'b1; best_q <= ridx_q; best_e_q <= rdata;
              end
            end
            if (scan_end) state_q <= StWrA0;
          end
          StWrA0: begin
            if (best_v_q && slot_v_q) begin
              state_q <= StWrA1;
            end else begin
              res_q <= '0; ok_q <= 1'b0; state_q <= StDone;
            end
          end
          StWrA1: begin
            res_q <= d_off; ok_q <= 1'b1; state_q <= StDone;
          end
          StScanF: begin
            if (rvld_q && !cur_v_q && cur_hit) begin
              cur_v_q <= 1'b1; cur_q <= ridx_q; cur_e_q <= rdata;
            end
            if (scan_end) begin
              cnt_q <= '0;
              if (cur_v_q || cur_hit) begin
                state_q <= StScanN;
              end else begin
                res_q <= '0; ok_q <= 1'b0; state_q <= StDone;
              end
            end else if (cnt_q != LastCnt) begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
          StScanN: begin
            if (cnt_q != LastCnt) cnt_q <= cnt_q + 1'b1;
            if (rvld_q && ridx_q != cur_q && rdata.valid && !rdata.used) begin
              if (!nxt_v_q && {1'b0, rdata.start} == cur_end) begin
                nxt_v_q <= 1'b1; nxt_q <= ridx_q; nxt_e_q <= rdata;
              end else if (!prv_v_q && rd_end == {1'b0, cur_e_q.start}) begin
                prv_v_q <= 1'b1; prv_q <= ridx_q; prv_e_q <= rdata;
              end
            end
            if (scan_end) state_q <= StWrN;
          end
          StWrN: begin
            if (nxt_v_q) cur_e_q.size <= nxt_sz;
            state_q <= StWrP;
          end
          StWrP: begin
            state_q <= StWrC;
          end
          StWrC: begin
            res_q <= (prv_v_q ? prv_e_q.start : cur_e_q.start) + 32'(hdr_q);
            ok_q <= 1'b1; state_q <= StDone;
          end
          StDone: begin
            m_axis_tvalid <= 1'b1; state_q <= StIdle;
          end
          default: state_q <= StIdle;
        endcase
      end
    end
  end

endmodule

@@ src/bfa_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
module bfa_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ sim/tb.sv @@
// Testbench for the best-fit block allocator: directed table, then config corner cases and random alloc/free traffic.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned NumBlocks = 64;
  localparam int unsigned CycleLimit = 2_000_000;

  typedef struct packed {
    logic        op;
    logic [31:0] req;
    logic [31:0] off;
  } request_t;

  typedef struct packed {
    logic [31:0] offset;
    logic        ok;
  } answer_t;

  typedef struct {
    logic        op;
    logic [31:0] req;
    logic [31:0] off;
    logic        has_exp;
    logic [31:0] exp_off;
    logic        exp_ok;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [31:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;

  best_fit_block_allocator #(.MAX_BLOCKS(NumBlocks)) dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  // allocator mirror
  logic [31:0] pool_q;
  logic [11:0] hdr_q;
  logic [31:0] blk_start [NumBlocks];
  logic [31:0] blk_size  [NumBlocks];
  logic        blk_used  [NumBlocks];
  logic        blk_valid [NumBlocks];

  answer_t     answers_q [$];
  logic [31:0] live_offs [$];
  int          errors;
  int unsigned cycles;

  function automatic void rebuild_pool();
    for (int i = 0; i < NumBlocks; i++) begin
      blk_start[i] = '0;
      blk_size[i]  = '0;
      blk_used[i]  = 1'b0;
      blk_valid[i] = 1'b0;
    end
    blk_valid[0] = 1'b1;
    blk_size[0]  = (pool_q > 32'(hdr_q)) ? pool_q - 32'(hdr_q) : '0;
  endfunction

  function automatic logic [32:0] blk_end(int i);
    return 33'(blk_start[i]) + 33'(hdr_q) + 33'(blk_size[i]);
  endfunction

  function automatic answer_t allocate_block(logic [31:0] req);
    answer_t a;
    logic [32:0] need, data_off;
    int best, slot;
    a = '0;
    need = 33'(req) + 33'(hdr_q);
    best = -1;
    slot = -1;
    for (int i = 0; i < NumBlocks; i++) begin
      if (!blk_valid[i]) begin
        if (slot < 0) slot = i;
      end else if (!blk_used[i] && 33'(blk_size[i]) > need) begin
        if (best < 0 || blk_size[i] < blk_size[best]) best = i;
      end
    end
    if (best < 0 || slot < 0) return a;
    data_off = 33'(blk_start[best]) + 33'(hdr_q);
    blk_valid[slot] = 1'b1;
    blk_used[slot]  = 1'b0;
    blk_start[slot] = 32'(data_off + 33'(req));
    blk_size[slot]  = 32'(33'(blk_size[best]) - need);
    blk_used[best]  = 1'b1;
    blk_size[best]  = req;
    a.offset = 32'(data_off);
    a.ok = 1'b1;
    return a;
  endfunction

  function automatic answer_t release_block(logic [31:0] off);
    answer_t a;
    int cur, nxt, prv;
    a = '0;
    cur = -1;
    nxt = -1;
    prv = -1;
    for (int i = 0; i < NumBlocks; i++)
      if (cur < 0 && blk_valid[i] && blk_used[i] &&
          33'(blk_start[i]) + 33'(hdr_q) == 33'(off)) cur = i;
    if (cur < 0) return a;
    blk_used[cur] = 1'b0;
    for (int i = 0; i < NumBlocks; i++) begin
      if (i == cur || !blk_valid[i] || blk_used[i]) continue;
      if (nxt < 0 && 33'(blk_start[i]) == blk_end(cur)) nxt = i;
      else if (prv < 0 && blk_end(i) == 33'(blk_start[cur])) prv = i;
    end
    if (nxt >= 0) begin
      blk_size[cur] = 32'(33'(blk_size[cur]) + 33'(hdr_q) + 33'(blk_size[nxt]));
      blk_valid[nxt] = 1'b0;
      blk_size[nxt] = '0;
      blk_start[nxt] = '0;
    end
    if (prv >= 0) begin
      blk_size[prv] = 32'(33'(blk_size[prv]) + 33'(hdr_q) + 33'(blk_size[cur]));
      blk_valid[cur] = 1'b0;
      blk_size[cur] = '0;
      blk_start[cur] = '0;
      cur = prv;
    end
    a.offset = 32'(33'(blk_start[cur]) + 33'(hdr_q));
    a.ok = 1'b1;
    return a;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: compare and stall on a pattern
  int unsigned stall_cnt;
  always @(posedge clk_i) begin
    answer_t got, want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.offset = m_axis_tdata[31:0];
        got.ok = m_axis_tdata[32];
        if (answers_q.size() == 0) begin
          report_mismatch("unexpected beat", got.offset, '0);
        end else begin
          want = answers_q.pop_front();
          if (got.ok !== want.ok) report_mismatch("ok", 32'(got.ok), 32'(want.ok));
          if (got.offset !== want.offset) report_mismatch("offset", got.offset, want.offset);
        end
      end
      stall_cnt <= stall_cnt + 1;
      case (stall_cnt[9:8])
        2'd0: m_axis_tready <= 1'b1;
        2'd1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        2'd2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= stall_cnt[2];
      endcase
    end
  end

  int unsigned burst_left;

  task automatic send_beat(request_t r);
    answer_t a;
    while (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= r.op;
    s_axis_tdata <= {r.off, r.req};
    do @(posedge clk_i); while (!s_axis_tready);
    a = (r.op == bfa_pkg::OpAlloc) ? allocate_block(r.req) : release_block(r.off);
    answers_q.push_back(a);
    if (r.op == bfa_pkg::OpAlloc && a.ok) live_offs.push_back(a.offset);
    if (burst_left == 0) s_axis_tvalid <= 1'b0;
  endtask

  task automatic drain();
    if (burst_left != 0) s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (answers_q.size() != 0) @(posedge clk_i);
    repeat (2 * NumBlocks + 10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == bfa_pkg::CfgPoolSize) pool_q = val;
    else hdr_q = val[11:0];
    rebuild_pool();
    live_offs.delete();
  endtask

  task automatic random_phase(int n, logic [31:0] max_req);
    request_t r;
    int k;
    for (int i = 0; i < n; i++) begin
      r.req = $urandom_range(0, max_req);
      if ($urandom_range(0, 40) == 0) r.req = $urandom;
      r.off = $urandom;
      r.op = ($urandom_range(0, 99) < 50) ? bfa_pkg::OpAlloc : bfa_pkg::OpFree;
      if (r.op == bfa_pkg::OpFree && live_offs.size() != 0 && $urandom_range(0, 9) != 0) begin
        k = $urandom_range(0, live_offs.size() - 1);
        r.off = live_offs[k];
        // leave some in the list to provoke double frees
        if ($urandom_range(0, 7) != 0) live_offs.delete(k);
      end
      send_beat(r);
    end
  endtask

  dir_row_t dir_rows [] = '{
    '{bfa_pkg::OpAlloc, 32'd100, 32'd0, 1'b1, 32'd64, 1'b1},
    '{bfa_pkg::OpAlloc, 32'd0, 32'd0, 1'b1, 32'd228, 1'b1},
    '{bfa_pkg::OpAlloc, 32'hFFFF_FFFF, 32'd0, 1'b1, 32'd0, 1'b0},
    '{bfa_pkg::OpAlloc, 32'd2096000, 32'd0, 1'b1, 32'd292, 1'b1},
    '{bfa_pkg::OpFree, 32'd0, 32'd0, 1'b1, 32'd0, 1'b0},
    '{bfa_pkg::OpFree, 32'd0, 32'hFFFF_FFFF, 1'b1, 32'd0, 1'b0},
    '{bfa_pkg::OpAlloc, 32'd500, 32'd0, 1'b0, 32'd0, 1'b0},
    '{bfa_pkg::OpFree, 32'd0, 32'd228, 1'b0, 32'd0, 1'b0},
    '{bfa_pkg::OpFree, 32'd0, 32'd228, 1'b1, 32'd0, 1'b0},
    '{bfa_pkg::OpFree, 32'd0, 32'd64, 1'b0, 32'd0, 1'b0},
    '{bfa_pkg::OpAlloc, 32'd1000, 32'd0, 1'b0, 32'd0, 1'b0},
    '{bfa_pkg::OpAlloc, 32'd1000, 32'd0, 1'b0, 32'd0, 1'b0},
    '{bfa_pkg::OpFree, 32'd0, 32'd64, 1'b0, 32'd0, 1'b0},
    '{bfa_pkg::OpFree, 32'd0, 32'd1128, 1'b0, 32'd0, 1'b0}
  };

  initial begin
    request_t r;
    answer_t before_q;
    errors = 0;
    cycles = 0;
    stall_cnt = 0;
    burst_left = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = bfa_pkg::CfgPoolSize;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = bfa_pkg::OpAlloc;
    m_axis_tready = 1'b0;
    pool_q = bfa_pkg::PoolSizeReset;
    hdr_q = bfa_pkg::HeaderSizeReset;
    rebuild_pool();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      r.op = dir_rows[i].op;
      r.req = dir_rows[i].req;
      r.off = dir_rows[i].off;
      send_beat(r);
      if (dir_rows[i].has_exp) begin
        before_q = answers_q[$];
        if (before_q.ok !== dir_rows[i].exp_ok || before_q.offset !== dir_rows[i].exp_off)
          report_mismatch("directed row", before_q.offset, dir_rows[i].exp_off);
      end
    end
    drain();

    // zero header, zero request: offset 0 with ok set; then fill the table
    write_reg(bfa_pkg::CfgHeaderSize, 32'd0);
    r = '{bfa_pkg::OpAlloc, 32'd0, 32'd0};
    send_beat(r);
    for (int i = 0; i < NumBlocks + 2; i++) begin
      r = '{bfa_pkg::OpAlloc, 32'd3, 32'd0};
      send_beat(r);
    end
    drain();

    // pool below header: size saturates, nothing fits
    write_reg(bfa_pkg::CfgHeaderSize, 32'd4095);
    write_reg(bfa_pkg::CfgPoolSize, 32'd100);
    r = '{bfa_pkg::OpAlloc, 32'd0, 32'd0};
    send_beat(r);
    drain();
    write_reg(bfa_pkg::CfgPoolSize, 32'hFFFF_FFFF);
    r = '{bfa_pkg::OpAlloc, 32'hFFFF_0000, 32'd0};
    send_beat(r);
    random_phase(150, 32'hFFFF);
    drain();

    write_reg(bfa_pkg::CfgHeaderSize, 32'd16);
    write_reg(bfa_pkg::CfgPoolSize, 32'd4096);
    random_phase(400, 300);
    drain();

    write_reg(bfa_pkg::CfgHeaderSize, 32'd0);
    write_reg(bfa_pkg::CfgPoolSize, 32'd2000);
    random_phase(300, 100);
    drain();

    write_reg(bfa_pkg::CfgPoolSize, 32'd0);
    random_phase(20, 10);
    drain();

    write_reg(bfa_pkg::CfgPoolSize, bfa_pkg::PoolSizeReset);
    write_reg(bfa_pkg::CfgHeaderSize, 32'(bfa_pkg::HeaderSizeReset));
    random_phase(560, 32'h3_FFFF);
    drain();

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/bfa_pkg.sv
src/bfa_ram.sv
src/best_fit_block_allocator.sv
sim/tb.sv
